// ===== rtl/core/pair_keyed_count_hash_map_macros.svh =====
// Assertion macros shared by the pair keyed count hash map RTL.
`ifndef PAIR_KEYED_COUNT_HASH_MAP_MACROS_SVH
`define PAIR_KEYED_COUNT_HASH_MAP_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define PKHM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds across reset.
`define PKHM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/core/pkhm_pkg.sv =====
// Package with shared widths, codes and helper functions of the hash map.
`timescale 1ns / 1ps

package pkhm_pkg;

   localparam int BUCKETS_DEFAULT = 64;
   localparam int WAYS_DEFAULT    = 4;

   localparam int FUNC_W    = 2;
   localparam int KEY_BYTE_W = 8;
   localparam int KEY_W     = 2 * KEY_BYTE_W;
   localparam int CARS_IN_W = 16;
   localparam int COUNT_W   = 15;
   localparam int STATUS_W  = 2;
   localparam int ENTRY_W   = KEY_W + COUNT_W;
   localparam int SUM_W     = KEY_BYTE_W + 1;
   localparam int SUM_MAX   = 2 * ((1 << KEY_BYTE_W) - 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_UPDATE = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_LOOKUP = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_PRESENT   = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Largest shift of the bucket count that still fits under the biggest key sum,
   // or -1 when the bucket count alone is already larger.
   function automatic int max_shift(input int buckets);
      int k;
      k = -1;
      for (int i = 0; i < 10; i++) begin
         if ((buckets << i) <= SUM_MAX) begin
            k = i;
         end
      end
      return k;
   endfunction

endpackage

// ===== rtl/core/pkhm_req_if.sv =====
// Request channel interface: valid, ready and the request payload.
`timescale 1ns / 1ps

interface pkhm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [pkhm_pkg::FUNC_W-1:0]           func;
   logic [pkhm_pkg::KEY_BYTE_W-1:0]       key_first;
   logic [pkhm_pkg::KEY_BYTE_W-1:0]       key_second;
   logic signed [pkhm_pkg::CARS_IN_W-1:0] cars_in;

   modport source (output valid, output func, output key_first, output key_second,
                   output cars_in, input ready);
   modport sink   (input valid, input func, input key_first, input key_second,
                   input cars_in, output ready);
endinterface

// ===== rtl/core/pkhm_rsp_if.sv =====
// Response channel interface: valid, ready and the response payload.
`timescale 1ns / 1ps

interface pkhm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pkhm_pkg::STATUS_W-1:0] status;
   logic [pkhm_pkg::COUNT_W-1:0]  cars_out;

   modport source (output valid, output status, output cars_out, input ready);
   modport sink   (input valid, input status, input cars_out, output ready);
endinterface

// ===== rtl/core/pair_keyed_count_hash_map.sv =====
// Top level of the set associative count map keyed by a pair of bytes.
// Path: an accepted request is registered in the working stage while its bucket row is read,
// then its response is loaded into the output register once that register is empty or emptied.
// Throughput: one request per cycle while responses are taken; a request reads its bucket row
// and, on an insert or update, writes it back, forwarded if the next request hits that bucket.
// Reset: synchronous, clears every slot valid bit at once, so the table is empty at once;
// no clearing pass is needed and keys and counts in the RAM stay undefined until written.
`timescale 1ns / 1ps
`include "pair_keyed_count_hash_map_macros.svh"

module pair_keyed_count_hash_map #(
   parameter int BUCKETS = pkhm_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = pkhm_pkg::WAYS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   pkhm_req_if.sink   req_chan,
   pkhm_rsp_if.source rsp_chan
);

   // Widths that follow from the geometry of the table.
   localparam int BW        = $clog2(BUCKETS);
   localparam int WIW       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W     = WAYS * pkhm_pkg::ENTRY_W;
   localparam int SHIFT_MAX = pkhm_pkg::max_shift(BUCKETS);
   localparam bit IS_POW2   = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam int RW        = pkhm_pkg::SUM_W + 1;

   // The bucket is the key sum reduced modulo the bucket count. A power of two is a
   // mask; any other count is a short chain of conditional subtractions of shifted copies.
   function automatic logic [BW-1:0] bucket_of(input logic [pkhm_pkg::SUM_W-1:0] sum);
      logic [RW-1:0] r;
      r = {1'b0, sum};
      if (IS_POW2) begin
         r = r & RW'(BUCKETS - 1);
      end else begin
         for (int k = SHIFT_MAX; k >= 0; k--) begin
            if (r >= RW'(BUCKETS << k)) begin
               r = r - RW'(BUCKETS << k);
            end
         end
      end
      return r[BW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Request side. The bucket is computed straight from the request so that
   // the row read is issued in the accepting cycle.
   // ------------------------------------------------------------------
   logic                              req_accept;
   logic [pkhm_pkg::SUM_W-1:0]        req_sum;
   logic [BW-1:0]                     req_bucket;
   logic [pkhm_pkg::COUNT_W-1:0]      req_count;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_sum    = pkhm_pkg::SUM_W'(req_chan.key_first) +
                       pkhm_pkg::SUM_W'(req_chan.key_second);
   assign req_bucket = bucket_of(req_sum);
   // A negative count is stored as zero.
   assign req_count  = req_chan.cars_in[pkhm_pkg::CARS_IN_W-1] ?
                       '0 : req_chan.cars_in[pkhm_pkg::COUNT_W-1:0];

   // ------------------------------------------------------------------
   // Working stage: the accepted request, waiting for its bucket row.
   // ------------------------------------------------------------------
   logic                         s1_valid_ff, s1_valid_in;
   pkhm_pkg::func_type           s1_func_ff, s1_func_in;
   logic [pkhm_pkg::KEY_W-1:0]   s1_key_ff, s1_key_in;
   logic [pkhm_pkg::COUNT_W-1:0] s1_count_ff, s1_count_in;
   logic [BW-1:0]                s1_bucket_ff, s1_bucket_in;
   logic                         s1_fwd_ff, s1_fwd_in;
   logic [ROW_W-1:0]             s1_fwd_row_ff, s1_fwd_row_in;
   logic [WAYS-1:0]              s1_vbits_ff, s1_vbits_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   pkhm_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [pkhm_pkg::COUNT_W-1:0] rsp_cars_ff, rsp_cars_in;

   // Slot valid bits, one word of ways per bucket.
   logic [WAYS-1:0]              valid_ff [BUCKETS];

   logic                         s1_fire;
   logic [ROW_W-1:0]             ram_rd_data;
   logic [ROW_W-1:0]             row_cur;
   logic [ROW_W-1:0]             row_new;
   logic [WAYS-1:0]              vbits;
   logic [WAYS-1:0]              vbits_new;
   logic [WAYS-1:0]              match_vec;
   logic                         hit_any;
   logic                         free_any;
   logic [WIW-1:0]               hit_way;
   logic [WIW-1:0]               free_way;
   logic [WIW-1:0]               wr_way;
   logic [pkhm_pkg::COUNT_W-1:0] hit_count;
   logic                         ram_we;
   pkhm_pkg::status_type         status_res;
   logic [pkhm_pkg::COUNT_W-1:0] cars_res;

   // The stage moves on when the output register is empty or being emptied.
   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;

   // The row just written is not yet visible through the RAM read port when the
   // next request reads the same bucket in that cycle, so it is carried along.
   // The valid bits of the bucket are read into the stage at accept time in the
   // same way, with the bits being written forwarded when the bucket matches.
   assign row_cur = s1_fwd_ff ? s1_fwd_row_ff : ram_rd_data;
   assign vbits   = s1_vbits_ff;

   // Compare all ways of the bucket; the lowest matching way and the lowest free
   // way win.
   always_comb begin
      match_vec = '0;
      hit_way   = '0;
      free_way  = '0;
      hit_count = '0;
      for (int w = 0; w < WAYS; w++) begin
         match_vec[w] = vbits[w] &&
            (row_cur[w*pkhm_pkg::ENTRY_W + pkhm_pkg::COUNT_W +: pkhm_pkg::KEY_W] == s1_key_ff);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match_vec[w]) begin
            hit_way   = WIW'(w);
            hit_count = row_cur[w*pkhm_pkg::ENTRY_W +: pkhm_pkg::COUNT_W];
         end
         if (!vbits[w]) begin
            free_way = WIW'(w);
         end
      end
      hit_any  = |match_vec;
      free_any = ~&vbits;
   end

   // Decide the response and the write back for the request in the stage.
   always_comb begin
      status_res = pkhm_pkg::STATUS_OK;
      cars_res   = '0;
      ram_we     = 1'b0;
      wr_way     = free_way;
      vbits_new  = vbits;
      case (s1_func_ff)
         pkhm_pkg::FUNC_INSERT: begin
            if (hit_any) begin
               status_res = pkhm_pkg::STATUS_PRESENT;
            end else if (free_any) begin
               ram_we              = 1'b1;
               vbits_new[free_way] = 1'b1;
            end else begin
               status_res = pkhm_pkg::STATUS_FULL;
            end
         end
         pkhm_pkg::FUNC_UPDATE: begin
            if (hit_any) begin
               ram_we = 1'b1;
               wr_way = hit_way;
            end else if (free_any) begin
               ram_we              = 1'b1;
               vbits_new[free_way] = 1'b1;
            end else begin
               status_res = pkhm_pkg::STATUS_FULL;
            end
         end
         pkhm_pkg::FUNC_REMOVE: begin
            if (hit_any) begin
               vbits_new[hit_way] = 1'b0;
            end else begin
               status_res = pkhm_pkg::STATUS_NOT_FOUND;
            end
         end
         pkhm_pkg::FUNC_LOOKUP: begin
            if (hit_any) begin
               cars_res = hit_count;
            end else begin
               status_res = pkhm_pkg::STATUS_NOT_FOUND;
            end
         end
         default: begin
            status_res = pkhm_pkg::STATUS_NOT_FOUND;
         end
      endcase
      ram_we  = ram_we && s1_fire;
      row_new = row_cur;
      row_new[int'(wr_way)*pkhm_pkg::ENTRY_W +: pkhm_pkg::ENTRY_W] = {s1_key_ff, s1_count_ff};
   end

   // Next values of the working stage.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_func_in    = s1_func_ff;
      s1_key_in     = s1_key_ff;
      s1_count_in   = s1_count_ff;
      s1_bucket_in  = s1_bucket_ff;
      s1_fwd_in     = s1_fwd_ff;
      s1_fwd_row_in = s1_fwd_row_ff;
      s1_vbits_in   = s1_vbits_ff;
      if (req_accept) begin
         s1_valid_in   = 1'b1;
         s1_func_in    = pkhm_pkg::func_type'(req_chan.func);
         s1_key_in     = {req_chan.key_first, req_chan.key_second};
         s1_count_in   = req_count;
         s1_bucket_in  = req_bucket;
         s1_fwd_in     = ram_we && (req_bucket == s1_bucket_ff);
         s1_fwd_row_in = row_new;
         s1_vbits_in   = (s1_fire && (req_bucket == s1_bucket_ff)) ?
                         vbits_new : valid_ff[req_bucket];
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
         s1_fwd_in   = 1'b0;
      end
   end

   // Next values of the output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cars_in   = rsp_cars_ff;
      if (s1_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_res;
         rsp_cars_in   = cars_res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_fwd_ff    <= s1_fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff    <= s1_func_in;
      s1_key_ff     <= s1_key_in;
      s1_count_ff   <= s1_count_in;
      s1_bucket_ff  <= s1_bucket_in;
      s1_fwd_row_ff <= s1_fwd_row_in;
      s1_vbits_ff   <= s1_vbits_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cars_ff   <= rsp_cars_in;
   end

   // Reset empties the whole table at once by clearing the valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BUCKETS; b++) begin
            valid_ff[b] <= '0;
         end
      end else if (s1_fire) begin
         valid_ff[s1_bucket_ff] <= vbits_new;
      end
   end

   // Keys and counts, one row of all ways per bucket.
   pkhm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_bucket_ff),
      .wr_data (row_new),
      .rd_en   (req_accept),
      .rd_addr (req_bucket),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.cars_out = rsp_cars_ff;

   // A key is never held by two valid ways of one bucket.
   `PKHM_ASSERT(a_single_match, clock, reset,
      s1_valid_ff |-> $countones(match_vec) <= 1, "duplicate key in bucket")
   // The row RAM is written only by a request that leaves the stage.
   `PKHM_ASSERT(a_write_on_fire, clock, reset,
      ram_we |-> s1_fire, "row write without a moving request")
   // A nonzero count is returned only with a success status.
   `PKHM_ASSERT(a_cars_only_ok, clock, reset,
      rsp_valid_ff && (rsp_cars_ff != '0) |-> rsp_status_ff == pkhm_pkg::STATUS_OK,
      "count returned with a failing status")
   // A forwarded row always belongs to a request in the stage.
   `PKHM_ASSERT(a_fwd_needs_req, clock, reset,
      s1_fwd_ff |-> s1_valid_ff, "forwarded row without a request")
   // Reset leaves the stage and the output register empty.
   `PKHM_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !s1_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")

endmodule

// ===== rtl/core/pkhm_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module pkhm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read in the cycle of a write to the same address returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
